// File: hdl/hcb_pkg.sv
// Shared types, codes and constants of the Huffman code builder.
package hcb_pkg;

    // Node links, weights and the null child link.
    localparam int NODE_W = 9;
    localparam int WEIGHT_W = 32;
    localparam logic [NODE_W-1:0] NO_CHILD = 9'd511;

    // Operation codes of a command item; the spare code is ignored.
    localparam logic [1:0] OP_COUNT = 2'd0;
    localparam logic [1:0] OP_BUILD = 2'd1;
    localparam logic [1:0] OP_FETCH = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Kinds of a result item.
    localparam logic [1:0] KIND_CODE = 2'd0;
    localparam logic [1:0] KIND_BUILT = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    // One heap slot: the node it refers to and a copy of that node's weight.
    typedef struct packed {
        logic [NODE_W-1:0] idx;
        logic [WEIGHT_W-1:0] weight;
    } heap_ent_t;

    // One tree node.
    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [NODE_W-1:0] left;
        logic [NODE_W-1:0] right;
        logic [7:0] sym;
    } node_t;

    // Request to the histogram store.
    typedef struct packed {
        logic rd;
        logic inc;
        logic clr;
        logic [7:0] addr;
    } hist_cmd_t;

    // Payload of a result item.
    typedef struct packed {
        logic [1:0] kind;
        logic [8:0] distinct_symbols;
        logic [7:0] symbol;
        logic [5:0] code_length;
        logic [47:0] code_bits;
        logic last;
    } res_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CNT_WAIT,
        ST_LEAF_RD,
        ST_LEAF_WR,
        ST_SCAN_END,
        ST_HEAP_RD,
        ST_HEAP_LD,
        ST_SIFT_RD,
        ST_SIFT_CMP,
        ST_MERGE_TEST,
        ST_POP_RD,
        ST_POP_LD,
        ST_MERGE_WR,
        ST_PUSH_RD,
        ST_PUSH_CMP,
        ST_FIN_RD,
        ST_FIN_LD,
        ST_GL_RD,
        ST_GL_CHK,
        ST_NL_POP,
        ST_NL_STK,
        ST_NL_NODE,
        ST_WALK_END
    } state_t;

    // What a finished sift returns to.
    typedef enum logic [1:0] {
        SC_HEAPIFY,
        SC_POP_A,
        SC_POP_B
    } sift_ctx_t;

endpackage

// File: hdl/hcb_cmd_if.sv
// Command channel of the Huffman code builder.
interface hcb_cmd_if;
    logic valid;
    logic ready;
    logic [1:0] operation;
    logic [7:0] byte_value;

    modport source (output valid, output operation, output byte_value, input ready);
    modport sink (input valid, input operation, input byte_value, output ready);
endinterface

// File: hdl/hcb_res_if.sv
// Result channel of the Huffman code builder.
interface hcb_res_if;
    logic valid;
    logic ready;
    logic [1:0] kind;
    logic [8:0] distinct_symbols;
    logic [7:0] symbol;
    logic [5:0] code_length;
    logic [47:0] code_bits;
    logic last;

    modport source (output valid, output kind, output distinct_symbols, output symbol,
                    output code_length, output code_bits, output last, input ready);
    modport sink (input valid, input kind, input distinct_symbols, input symbol,
                  input code_length, input code_bits, input last, output ready);
endinterface

// File: hdl/hcb_hist.sv
// Histogram store with per-entry valid bits and a saturating increment.
module hcb_hist #(
    parameter int NUM_SYMBOLS = 256,
    parameter int COUNT_BITS = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hcb_pkg::hist_cmd_t     cmd,
    output logic [COUNT_BITS-1:0]  rdata
);
    import hcb_pkg::*;

    localparam int SYM_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

    logic [COUNT_BITS-1:0] mem [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0] valid_reg;
    logic [COUNT_BITS-1:0] rdata_reg;
    logic pend_reg;
    logic [SYM_W-1:0] paddr_reg;
    logic [SYM_W-1:0] addr;
    logic do_write;

    assign addr = cmd.addr[SYM_W-1:0];
    assign do_write = pend_reg && (rdata_reg != {COUNT_BITS{1'b1}});
    assign rdata = rdata_reg;

    // Registered read; an entry never written since the last clear reads as zero.
    always_ff @(posedge clk)
    begin
        if (cmd.rd || cmd.inc)
        begin
            rdata_reg <= valid_reg[addr] ? mem[addr] : '0;
            paddr_reg <= addr;
        end
        if (do_write)
        begin
            mem[paddr_reg] <= rdata_reg + 1'b1;
        end
    end

    // Increment pending flag and valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            pend_reg <= cmd.inc;
            if (cmd.clr)
            begin
                valid_reg <= '0;
            end
            else if (do_write)
            begin
                valid_reg[paddr_reg] <= 1'b1;
            end
        end
    end

endmodule

// File: hdl/huffman_code_builder_core.sv
// Top level of the Huffman code builder: sequencer, heap, tree and walk stack.
//
// Commands arrive on the cmd channel, one item per handshake (valid and ready
// high at a rising edge). Operation 0 counts a byte into the histogram and
// gives no result, by a read-modify-write of the histogram store. Operation
// 1 builds the tree: a scan of the histogram symbol by symbol, then heap
// sifts level by level over the one heap port pair, then a walk down left
// links to the first leaf. Operation 2 returns the next code; it climbs past
// right turns, then takes the next right branch and descends left links.
// Each build or fetch gives one result item on the res channel, held in an
// output register until taken. The block accepts a new item only while idle
// and while the output register is free or being emptied, so a stalled
// receiver holds up further commands. Reset empties the histogram at once by
// its valid bits, drops any pending walk and clears the output register.
module huffman_code_builder_core #(
    parameter int NUM_SYMBOLS = 256,
    parameter int COUNT_BITS = 24,
    parameter int MAX_CODE_LEN = 48
) (
    input logic clk,
    input logic rst_n,
    hcb_cmd_if.sink cmd,
    hcb_res_if.source res
);
    import hcb_pkg::*;

    localparam int NODE_COUNT = 2 * NUM_SYMBOLS - 1;
    localparam int SYM_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int CNT_W = $clog2(NUM_SYMBOLS + 1);
    localparam int HPOS_W = $clog2(2 * NUM_SYMBOLS + 1);
    localparam int NIDX_W = $clog2(NODE_COUNT);
    localparam int STK_W = $clog2(MAX_CODE_LEN);

    // Registers.
    state_t state_reg, state_next;
    sift_ctx_t sctx_reg, sctx_next;
    logic [SYM_W-1:0] s_reg, s_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] heap_size_reg, heap_size_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [HPOS_W-1:0] at_reg, at_next;
    heap_ent_t x_reg, x_next;
    heap_ent_t a_reg, a_next;
    heap_ent_t b_reg, b_next;
    logic [NODE_W-1:0] fresh_reg, fresh_next;
    logic [NODE_W-1:0] cursor_reg, cursor_next;
    logic [5:0] depth_reg, depth_next;
    logic [47:0] path_reg, path_next;
    logic walk_reg, walk_next;
    logic fetch_walk_reg, fetch_walk_next;
    logic found_reg, found_next;
    logic [7:0] cur_sym_reg, cur_sym_next;
    logic out_valid_reg, out_valid_next;
    res_t out_data_reg, out_data_next;

    // Memory ports.
    node_t node_mem [NODE_COUNT];
    heap_ent_t heap_mem [NUM_SYMBOLS];
    logic [NODE_W-1:0] stack_mem [MAX_CODE_LEN];
    node_t nd_q;
    heap_ent_t hp_a_q, hp_b_q;
    logic [NODE_W-1:0] st_q;
    logic nd_we, hp_we, st_we;
    logic [NODE_W-1:0] nd_waddr, nd_ra;
    node_t nd_wdata;
    logic [HPOS_W-1:0] hp_waddr, hp_ra, hp_rb;
    heap_ent_t hp_wdata;
    logic [5:0] st_ra;
    hist_cmd_t hist_cmd;
    logic [COUNT_BITS-1:0] hist_q;
    logic emit;

    // Shared decisions.
    logic accept;
    logic in_range;
    logic [HPOS_W-1:0] size_ext, l_pos, r_pos, parent_pos, best_pos;
    logic sel_l, sel_r, sift_move;
    logic [WEIGHT_W-1:0] w_after;
    heap_ent_t best_ent;
    logic merge_go, cur_big, is_leaf, depth_full, nl_pop, push_up;
    logic [WEIGHT_W-1:0] merge_sum;

    assign cmd.ready = (state_reg == ST_IDLE) && (!out_valid_reg || res.ready);
    assign accept = cmd.valid && cmd.ready;
    assign in_range = {1'b0, cmd.byte_value} < 9'(NUM_SYMBOLS);

    assign size_ext = HPOS_W'(heap_size_reg);
    assign l_pos = HPOS_W'({at_reg, 1'b1});
    assign r_pos = l_pos + 1'b1;
    assign parent_pos = (at_reg - 1'b1) >> 1;
    assign sel_l = (l_pos < size_ext) && (hp_a_q.weight < x_reg.weight);
    assign w_after = sel_l ? hp_a_q.weight : x_reg.weight;
    assign sel_r = (r_pos < size_ext) && (hp_b_q.weight < w_after);
    assign sift_move = sel_l || sel_r;
    assign best_pos = sel_r ? r_pos : l_pos;
    assign best_ent = sel_r ? hp_b_q : hp_a_q;
    assign push_up = x_reg.weight < hp_a_q.weight;
    assign merge_go = (heap_size_reg > CNT_W'(1)) && (fresh_reg < NODE_W'(NODE_COUNT));
    assign merge_sum = a_reg.weight + b_reg.weight;
    assign cur_big = cursor_reg >= NODE_W'(NODE_COUNT);
    assign is_leaf = (nd_q.left == NO_CHILD) && (nd_q.right == NO_CHILD);
    assign depth_full = depth_reg >= 6'(MAX_CODE_LEN);
    assign nl_pop = (depth_reg != 6'd0) && path_reg[0];

    // Histogram store.
    hcb_hist #(
        .NUM_SYMBOLS(NUM_SYMBOLS),
        .COUNT_BITS(COUNT_BITS)
    ) u_hist (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(hist_cmd),
        .rdata(hist_q)
    );

    // Node memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (nd_we)
        begin
            node_mem[nd_waddr[NIDX_W-1:0]] <= nd_wdata;
        end
        nd_q <= node_mem[nd_ra[NIDX_W-1:0]];
    end

    // Heap memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (hp_we)
        begin
            heap_mem[hp_waddr[SYM_W-1:0]] <= hp_wdata;
        end
        hp_a_q <= heap_mem[hp_ra[SYM_W-1:0]];
        hp_b_q <= heap_mem[hp_rb[SYM_W-1:0]];
    end

    // Walk stack: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            stack_mem[depth_reg[STK_W-1:0]] <= cursor_reg;
        end
        st_q <= stack_mem[st_ra[STK_W-1:0]];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.operation)
                        OP_COUNT:
                        begin
                            if (in_range)
                            begin
                                state_next = ST_CNT_WAIT;
                            end
                        end
                        OP_BUILD: state_next = ST_LEAF_RD;
                        OP_FETCH:
                        begin
                            if (walk_reg && !cur_big)
                            begin
                                state_next = ST_NL_POP;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CNT_WAIT: state_next = ST_IDLE;
            ST_LEAF_RD: state_next = ST_LEAF_WR;
            ST_LEAF_WR:
            begin
                state_next = (s_reg == SYM_W'(NUM_SYMBOLS - 1)) ? ST_SCAN_END : ST_LEAF_RD;
            end
            ST_SCAN_END: state_next = (n_reg == '0) ? ST_IDLE : ST_HEAP_RD;
            ST_HEAP_RD: state_next = ST_HEAP_LD;
            ST_HEAP_LD: state_next = ST_SIFT_RD;
            ST_SIFT_RD: state_next = ST_SIFT_CMP;
            ST_SIFT_CMP:
            begin
                if (sift_move)
                begin
                    state_next = ST_SIFT_RD;
                end
                else
                begin
                    case (sctx_reg)
                        SC_HEAPIFY: state_next = (i_reg == '0) ? ST_MERGE_TEST : ST_HEAP_RD;
                        SC_POP_A: state_next = ST_POP_RD;
                        default: state_next = ST_MERGE_WR;
                    endcase
                end
            end
            ST_MERGE_TEST: state_next = merge_go ? ST_POP_RD : ST_FIN_RD;
            ST_POP_RD: state_next = ST_POP_LD;
            ST_POP_LD: state_next = ST_SIFT_RD;
            ST_MERGE_WR: state_next = ST_PUSH_RD;
            ST_PUSH_RD: state_next = (at_reg == '0) ? ST_MERGE_TEST : ST_PUSH_CMP;
            ST_PUSH_CMP: state_next = push_up ? ST_PUSH_RD : ST_MERGE_TEST;
            ST_FIN_RD: state_next = ST_FIN_LD;
            ST_FIN_LD: state_next = ST_GL_RD;
            ST_GL_RD: state_next = cur_big ? ST_NL_POP : ST_GL_CHK;
            ST_GL_CHK:
            begin
                if (is_leaf)
                begin
                    state_next = ST_WALK_END;
                end
                else if (depth_full)
                begin
                    state_next = ST_NL_POP;
                end
                else
                begin
                    state_next = ST_GL_RD;
                end
            end
            ST_NL_POP:
            begin
                if (nl_pop)
                begin
                    state_next = ST_NL_POP;
                end
                else if (depth_reg == 6'd0)
                begin
                    state_next = ST_WALK_END;
                end
                else
                begin
                    state_next = ST_NL_STK;
                end
            end
            ST_NL_STK: state_next = ST_NL_NODE;
            ST_NL_NODE: state_next = ST_GL_RD;
            ST_WALK_END: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory controls and result register.
    always_comb
    begin
        sctx_next = sctx_reg;
        s_next = s_reg;
        n_next = n_reg;
        heap_size_next = heap_size_reg;
        i_next = i_reg;
        at_next = at_reg;
        x_next = x_reg;
        a_next = a_reg;
        b_next = b_reg;
        fresh_next = fresh_reg;
        cursor_next = cursor_reg;
        depth_next = depth_reg;
        path_next = path_reg;
        walk_next = walk_reg;
        fetch_walk_next = fetch_walk_reg;
        found_next = found_reg;
        cur_sym_next = cur_sym_reg;
        out_data_next = out_data_reg;
        emit = 1'b0;
        nd_we = 1'b0;
        nd_waddr = fresh_reg;
        nd_wdata = '0;
        nd_ra = cursor_reg;
        hp_we = 1'b0;
        hp_waddr = at_reg;
        hp_wdata = x_reg;
        hp_ra = l_pos;
        hp_rb = r_pos;
        st_we = 1'b0;
        st_ra = depth_reg - 1'b1;
        hist_cmd = '0;
        hist_cmd.addr = 8'(s_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.operation)
                        OP_COUNT:
                        begin
                            hist_cmd.inc = in_range;
                            hist_cmd.addr = cmd.byte_value;
                        end
                        OP_BUILD:
                        begin
                            s_next = '0;
                            n_next = '0;
                        end
                        OP_FETCH:
                        begin
                            out_data_next = '0;
                            if (walk_reg && !cur_big)
                            begin
                                out_data_next.kind = KIND_CODE;
                                out_data_next.symbol = cur_sym_reg;
                                out_data_next.code_length = depth_reg;
                                out_data_next.code_bits = path_reg;
                                fetch_walk_next = 1'b1;
                            end
                            else
                            begin
                                out_data_next.kind = KIND_NONE;
                                emit = 1'b1;
                            end
                        end
                        default: emit = 1'b0;
                    endcase
                end
            end
            // Scan the histogram into leaves and heap slots.
            ST_LEAF_RD:
            begin
                hist_cmd.rd = 1'b1;
            end
            ST_LEAF_WR:
            begin
                if (hist_q != '0)
                begin
                    nd_we = 1'b1;
                    nd_waddr = NODE_W'(n_reg);
                    nd_wdata.weight = WEIGHT_W'(hist_q);
                    nd_wdata.left = NO_CHILD;
                    nd_wdata.right = NO_CHILD;
                    nd_wdata.sym = 8'(s_reg);
                    hp_we = 1'b1;
                    hp_waddr = HPOS_W'(n_reg);
                    hp_wdata.idx = NODE_W'(n_reg);
                    hp_wdata.weight = WEIGHT_W'(hist_q);
                    n_next = n_reg + 1'b1;
                end
                s_next = s_reg + 1'b1;
            end
            ST_SCAN_END:
            begin
                if (n_reg == '0)
                begin
                    heap_size_next = '0;
                    walk_next = 1'b0;
                    out_data_next = '0;
                    out_data_next.kind = KIND_EMPTY;
                    emit = 1'b1;
                end
                else
                begin
                    heap_size_next = n_reg;
                    i_next = (n_reg - 1'b1) >> 1;
                    sctx_next = SC_HEAPIFY;
                end
            end
            // Bottom-up heapify.
            ST_HEAP_RD:
            begin
                hp_ra = HPOS_W'(i_reg);
            end
            ST_HEAP_LD:
            begin
                x_next = hp_a_q;
                at_next = HPOS_W'(i_reg);
            end
            // Sift the held slot down one level per pass.
            ST_SIFT_CMP:
            begin
                hp_we = 1'b1;
                if (sift_move)
                begin
                    hp_wdata = best_ent;
                    at_next = best_pos;
                end
                else
                begin
                    case (sctx_reg)
                        SC_HEAPIFY: i_next = i_reg - 1'b1;
                        SC_POP_A: sctx_next = SC_POP_B;
                        default: sctx_next = SC_POP_B;
                    endcase
                end
            end
            ST_MERGE_TEST:
            begin
                sctx_next = SC_POP_A;
            end
            // Pop the smallest slot.
            ST_POP_RD:
            begin
                hp_ra = '0;
                hp_rb = size_ext - 1'b1;
            end
            ST_POP_LD:
            begin
                if (sctx_reg == SC_POP_A)
                begin
                    a_next = hp_a_q;
                end
                else
                begin
                    b_next = hp_a_q;
                end
                x_next = hp_b_q;
                heap_size_next = heap_size_reg - 1'b1;
                at_next = '0;
            end
            // Join the two popped nodes and push the new one.
            ST_MERGE_WR:
            begin
                nd_we = 1'b1;
                nd_wdata.weight = merge_sum;
                nd_wdata.left = a_reg.idx;
                nd_wdata.right = b_reg.idx;
                nd_wdata.sym = 8'd0;
                x_next.idx = fresh_reg;
                x_next.weight = merge_sum;
                at_next = size_ext;
                heap_size_next = heap_size_reg + 1'b1;
            end
            ST_PUSH_RD:
            begin
                hp_ra = parent_pos;
                if (at_reg == '0)
                begin
                    hp_we = 1'b1;
                    fresh_next = fresh_reg + 1'b1;
                end
            end
            ST_PUSH_CMP:
            begin
                hp_we = 1'b1;
                if (push_up)
                begin
                    hp_wdata = hp_a_q;
                    at_next = parent_pos;
                end
                else
                begin
                    fresh_next = fresh_reg + 1'b1;
                end
            end
            // Take the root and start the walk.
            ST_FIN_RD:
            begin
                hp_ra = '0;
            end
            ST_FIN_LD:
            begin
                cursor_next = hp_a_q.idx;
                heap_size_next = '0;
                depth_next = '0;
                path_next = '0;
                fetch_walk_next = 1'b0;
            end
            // Descend along left links.
            ST_GL_CHK:
            begin
                if (is_leaf)
                begin
                    cur_sym_next = nd_q.sym;
                    found_next = 1'b1;
                end
                else if (!depth_full)
                begin
                    st_we = 1'b1;
                    depth_next = depth_reg + 1'b1;
                    path_next = {path_reg[46:0], 1'b0};
                    cursor_next = nd_q.left;
                end
            end
            // Climb past right turns, then take the next right branch.
            ST_NL_POP:
            begin
                if (nl_pop)
                begin
                    depth_next = depth_reg - 1'b1;
                    path_next = {1'b0, path_reg[47:1]};
                end
                else if (depth_reg == 6'd0)
                begin
                    found_next = 1'b0;
                end
                else
                begin
                    path_next = {path_reg[47:1], 1'b1};
                end
            end
            ST_NL_STK:
            begin
                nd_ra = st_q;
            end
            ST_NL_NODE:
            begin
                cursor_next = nd_q.right;
            end
            ST_WALK_END:
            begin
                emit = 1'b1;
                if (fetch_walk_reg)
                begin
                    out_data_next.last = !found_reg;
                    if (!found_reg)
                    begin
                        walk_next = 1'b0;
                        depth_next = '0;
                        path_next = '0;
                        hist_cmd.clr = 1'b1;
                    end
                end
                else
                begin
                    walk_next = found_reg;
                    out_data_next = '0;
                    out_data_next.kind = KIND_BUILT;
                    out_data_next.distinct_symbols = 9'(n_reg);
                end
            end
            default: emit = 1'b0;
        endcase

        out_valid_next = emit ? 1'b1 : (out_valid_reg && !res.ready);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            walk_reg <= 1'b0;
            heap_size_reg <= '0;
            depth_reg <= '0;
            path_reg <= '0;
            cursor_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            walk_reg <= walk_next;
            heap_size_reg <= heap_size_next;
            depth_reg <= depth_next;
            path_reg <= path_next;
            cursor_reg <= cursor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        sctx_reg <= sctx_next;
        s_reg <= s_next;
        n_reg <= n_next;
        i_reg <= i_next;
        at_reg <= at_next;
        x_reg <= x_next;
        a_reg <= a_next;
        b_reg <= b_next;
        fresh_reg <= (state_reg == ST_SCAN_END) ? NODE_W'(n_reg) : fresh_next;
        fetch_walk_reg <= fetch_walk_next;
        found_reg <= found_next;
        cur_sym_reg <= cur_sym_next;
        out_data_reg <= out_data_next;
    end

    // Result channel.
    assign res.valid = out_valid_reg;
    assign res.kind = out_data_reg.kind;
    assign res.distinct_symbols = out_data_reg.distinct_symbols;
    assign res.symbol = out_data_reg.symbol;
    assign res.code_length = out_data_reg.code_length;
    assign res.code_bits = out_data_reg.code_bits;
    assign res.last = out_data_reg.last;

    // A result is only produced into a free or draining output register.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || res.ready))
        else $error("result produced over an untaken result");

    // The heap never holds more slots than symbols.
    a_heap_size: assert property (@(posedge clk) disable iff (!rst_n)
        heap_size_reg <= CNT_W'(NUM_SYMBOLS))
        else $error("heap size beyond alphabet");

    // A sifting slot lies inside the heap, or at the root of a heap just emptied.
    a_sift_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIFT_CMP) |-> ((at_reg < size_ext) || (at_reg == '0)))
        else $error("sift position outside heap");

    // The walk never goes deeper than the code length limit.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= 6'(MAX_CODE_LEN))
        else $error("walk depth beyond limit");

    // A stack push only happens below the limit and grows the depth next cycle.
    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        st_we |-> ((depth_reg < 6'(MAX_CODE_LEN)) ##1 (depth_reg == $past(depth_reg) + 6'd1)))
        else $error("walk stack push out of order");

endmodule
